### src/scs_pkg.sv
// types, constants and stage functions shared by the comment stripper modules
`timescale 1ns / 1ps
`default_nettype none

package scs_pkg;

    localparam int MAX_OUT = 4;

    typedef logic [7:0] byte_t;

    localparam byte_t CH_SLASH = 8'h2F;
    localparam byte_t CH_STAR  = 8'h2A;
    localparam byte_t CH_SPACE = 8'h20;
    localparam byte_t CH_NL    = 8'h0A;
    localparam byte_t CH_TAB   = 8'h09;
    localparam byte_t CH_CR    = 8'h0D;

    // block comment tracker
    typedef enum logic [3:0] {
        BP_NORMAL = 4'b0001,
        BP_SLASH  = 4'b0010,
        BP_IN     = 4'b0100,
        BP_STAR   = 4'b1000
    } block_phase_t;

    // line comment tracker
    typedef enum logic [2:0] {
        LP_NORMAL = 3'b001,
        LP_SLASH  = 3'b010,
        LP_IN     = 3'b100
    } line_phase_t;

    // working record of one request as it passes the stages
    typedef struct packed {
        block_phase_t         bphase;
        line_phase_t          lphase;
        logic                 seen;
        logic                 pend;
        logic [3:0][7:0]      data;
        logic [2:0]           cnt;
    } strip_t;

    // results caused by one request
    typedef struct packed {
        logic [3:0][7:0]      data;
        logic [2:0]           count;
        logic                 valid;
        logic                 last;
    } group_t;

    // queue status seen by front and back
    typedef struct packed {
        logic avail;
        logic space;
    } q_status_t;

    function automatic logic is_white(byte_t b);
        return (b == CH_SPACE) || (b == CH_NL) || (b == CH_TAB) || (b == CH_CR);
    endfunction

    function automatic strip_t push_byte(strip_t s, byte_t b);
        strip_t r;
        r = s;
        if (r.cnt < 3'(MAX_OUT))
        begin
            r.data[r.cnt[1:0]] = b;
            r.cnt = r.cnt + 3'd1;
        end
        return r;
    endfunction

    // collapse and trim
    function automatic strip_t stage_space(strip_t s, byte_t b);
        strip_t r;
        r = s;
        if (is_white(b))
        begin
            if (r.seen)
                r.pend = 1'b1;
        end
        else
        begin
            if (r.pend)
                r = push_byte(r, CH_SPACE);
            r.pend = 1'b0;
            r.seen = 1'b1;
            r = push_byte(r, b);
        end
        return r;
    endfunction

    // line comments
    function automatic strip_t stage_line(strip_t s, byte_t b);
        strip_t r;
        r = s;
        unique case (r.lphase)
            LP_IN:
            begin
                if (b == CH_NL)
                begin
                    r.lphase = LP_NORMAL;
                    r = stage_space(r, b);
                end
            end
            LP_SLASH:
            begin
                if (b == CH_SLASH)
                    r.lphase = LP_IN;
                else
                begin
                    r.lphase = LP_NORMAL;
                    r = stage_space(r, CH_SLASH);
                    r = stage_space(r, b);
                end
            end
            default:
            begin
                if (b == CH_SLASH)
                    r.lphase = LP_SLASH;
                else
                    r = stage_space(r, b);
            end
        endcase
        return r;
    endfunction

    // block comments
    function automatic strip_t stage_block(strip_t s, byte_t b);
        strip_t r;
        r = s;
        unique case (r.bphase)
            BP_IN:
            begin
                if (b == CH_STAR)
                    r.bphase = BP_STAR;
            end
            BP_STAR:
            begin
                if (b == CH_SLASH)
                    r.bphase = BP_NORMAL;
                else if (b != CH_STAR)
                    r.bphase = BP_IN;
            end
            BP_SLASH:
            begin
                if (b == CH_STAR)
                    r.bphase = BP_IN;
                else
                begin
                    r.bphase = BP_NORMAL;
                    r = stage_line(r, CH_SLASH);
                    if (b == CH_SLASH)
                        r.bphase = BP_SLASH;
                    else
                        r = stage_line(r, b);
                end
            end
            default:
            begin
                if (b == CH_SLASH)
                    r.bphase = BP_SLASH;
                else
                    r = stage_line(r, b);
            end
        endcase
        return r;
    endfunction

    // release held slashes at end of text
    function automatic strip_t flush_all(strip_t s);
        strip_t r;
        r = s;
        if (r.bphase == BP_SLASH)
            r = stage_line(r, CH_SLASH);
        if (r.lphase == LP_SLASH)
            r = stage_space(r, CH_SLASH);
        return r;
    endfunction

endpackage

`default_nettype wire

### src/scs_front.sv
// front end: accepts text bytes, runs the stripping stages, builds result groups
`timescale 1ns / 1ps
`default_nettype none

module scs_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         text_byte,
    input  wire logic               text_end,
    input  wire scs_pkg::q_status_t q_stat,
    output logic                    push,
    output scs_pkg::group_t         grp
);

    scs_pkg::block_phase_t bphase_reg, bphase_next;
    scs_pkg::line_phase_t  lphase_reg, lphase_next;
    logic                  seen_reg, seen_next;
    logic                  pend_reg, pend_next;

    scs_pkg::strip_t       cur;
    scs_pkg::strip_t       res;
    logic                  accept;

    assign in_ready = q_stat.space;
    assign accept   = in_valid & in_ready;

    always_comb
    begin
        cur.bphase = bphase_reg;
        cur.lphase = lphase_reg;
        cur.seen   = seen_reg;
        cur.pend   = pend_reg;
        cur.data   = '0;
        cur.cnt    = '0;
        res = scs_pkg::stage_block(cur, text_byte);
        if (text_end)
            res = scs_pkg::flush_all(res);
    end

    // empty terminator when the final byte gives nothing
    always_comb
    begin
        grp.last = text_end;
        if (res.cnt == 3'd0)
        begin
            grp.data  = '0;
            grp.count = 3'd1;
            grp.valid = 1'b0;
        end
        else
        begin
            grp.data  = res.data;
            grp.count = res.cnt;
            grp.valid = 1'b1;
        end
    end

    assign push = accept & ((res.cnt != 3'd0) | text_end);

    always_comb
    begin
        bphase_next = bphase_reg;
        lphase_next = lphase_reg;
        seen_next   = seen_reg;
        pend_next   = pend_reg;
        if (accept)
        begin
            if (text_end)
            begin
                bphase_next = scs_pkg::BP_NORMAL;
                lphase_next = scs_pkg::LP_NORMAL;
                seen_next   = 1'b0;
                pend_next   = 1'b0;
            end
            else
            begin
                bphase_next = res.bphase;
                lphase_next = res.lphase;
                seen_next   = res.seen;
                pend_next   = res.pend;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bphase_reg <= scs_pkg::BP_NORMAL;
            lphase_reg <= scs_pkg::LP_NORMAL;
            seen_reg   <= 1'b0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            bphase_reg <= bphase_next;
            lphase_reg <= lphase_next;
            seen_reg   <= seen_next;
            pend_reg   <= pend_next;
        end
    end

endmodule

`default_nettype wire

### src/scs_queue.sv
// short queue of result groups between front and back
`timescale 1ns / 1ps
`default_nettype none

module scs_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire scs_pkg::group_t push_grp,
    input  wire logic            pop,
    output scs_pkg::group_t      head_grp,
    output scs_pkg::q_status_t   q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    scs_pkg::group_t  mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign q_stat.avail = (count_reg != '0);
    assign q_stat.space = (count_reg != CNT_W'(DEPTH));
    assign do_push      = push & q_stat.space;
    assign do_pop       = pop & q_stat.avail;
    assign head_grp     = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_grp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

### src/scs_back.sv
// back end: unpacks groups, one result per cycle unless stalled
`timescale 1ns / 1ps
`default_nettype none

module scs_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire scs_pkg::group_t    head_grp,
    input  wire scs_pkg::q_status_t q_stat,
    output logic                    pop,
    output logic                    res_valid,
    input  wire logic               res_ready,
    output logic [7:0]              out_byte,
    output logic                    out_valid,
    output logic                    out_end
);

    scs_pkg::group_t cur_reg, cur_next;
    logic [1:0]      idx_reg, idx_next;
    logic            have_reg, have_next;
    logic            fire;
    logic            at_last;

    assign fire    = have_reg & res_ready;
    assign at_last = ({1'b0, idx_reg} + 3'd1) == cur_reg.count;
    assign pop     = q_stat.avail & (~have_reg | (fire & at_last));

    assign res_valid = have_reg;
    assign out_byte  = cur_reg.data[idx_reg];
    assign out_valid = cur_reg.valid;
    assign out_end   = cur_reg.last & at_last;

    always_comb
    begin
        cur_next  = cur_reg;
        idx_next  = idx_reg;
        have_next = have_reg;
        if (pop)
        begin
            cur_next  = head_grp;
            idx_next  = 2'd0;
            have_next = 1'b1;
        end
        else if (fire)
        begin
            if (at_last)
                have_next = 1'b0;
            else
                idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= 2'd0;
            have_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            have_reg <= have_next;
        end
    end

endmodule

`default_nettype wire

### src/source_text_comment_stripper_top.sv
// top level of the comment stripper: front end, group queue and back end
`timescale 1ns / 1ps
`default_nettype none

// channel   handshake              payload
// input     in_valid / in_ready    text_byte[7:0], text_end
// result    res_valid / res_ready  out_byte[7:0], out_valid, out_end
//
// one text byte is taken every cycle while the group queue has room; a byte
// that yields n results (0 to 4) hands the back end n results to send out
// first result of a byte passes through the queue and then the back end's group
// register before it is offered on the result channel
// reset clears the stripping state and empties the queue; no clearing pass
// a stalled result side fills the QUEUE_DEPTH-entry queue, then in_ready drops

module source_text_comment_stripper_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] text_byte,
    input  wire logic       text_end,
    output logic            res_valid,
    input  wire logic       res_ready,
    output logic [7:0]      out_byte,
    output logic            out_valid,
    output logic            out_end
);

    // front to queue
    logic               q_push;
    scs_pkg::group_t    push_grp;
    // queue to back
    logic               q_pop;
    scs_pkg::group_t    head_grp;
    scs_pkg::q_status_t q_stat;

    // classification of each byte through the comment and space stages
    scs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .text_byte (text_byte),
        .text_end  (text_end),
        .q_stat    (q_stat),
        .push      (q_push),
        .grp       (push_grp)
    );

    // decouples the two sides so each can stall on its own
    scs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_grp (push_grp),
        .pop      (q_pop),
        .head_grp (head_grp),
        .q_stat   (q_stat)
    );

    // serialises each group into single results
    scs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_grp  (head_grp),
        .q_stat    (q_stat),
        .pop       (q_pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .out_byte  (out_byte),
        .out_valid (out_valid),
        .out_end   (out_end)
    );

    // a group is only written while the queue has room
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> q_stat.space)
    else $error("group pushed into a full queue");

    // an empty terminator is a lone result that closes the text
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push && !push_grp.valid |-> push_grp.last && (push_grp.count == 3'd1))
    else $error("empty result not a lone terminator");

    // a result without a character must be the end of the text
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !out_valid |-> out_end)
    else $error("empty result before end of text");

    // the back end never takes a group that is not there
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_stat.avail)
    else $error("pop from an empty queue");

endmodule

`default_nettype wire
